// ----- rtl/apa_pkg.sv -----
`default_nettype none
package apa_pkg;

	localparam int RAW_W    = 16;
	localparam int CORR_W   = RAW_W + 1;
	localparam int SQR_W    = 2 * CORR_W;
	localparam int RAD_W    = SQR_W + 1 + 16;
	localparam int ROOT_W   = 26;
	localparam int CRD_W    = 28;
	localparam int ATAN_W   = 25;
	localparam int ATAN_LEN = 24;
	localparam int PITCH_W  = 15;
	localparam int IDX_W    = 2;
	localparam int OFF_W    = 48;
	localparam int DATA_W   = 64;
	localparam int ADDR_W   = 5;

	localparam logic [IDX_W-1:0] REG_OFF0 = 2'd0;
	localparam logic [IDX_W-1:0] REG_OFF1 = 2'd1;
	localparam logic [IDX_W-1:0] REG_OFF2 = 2'd2;
	localparam int REG_COUNT = 3;

	typedef struct packed {
		logic [IDX_W-1:0]         idx;
		logic signed [CORR_W-1:0] cx;
		logic                     zero;
	} side_t;

	// atan(2^-i) in 1/4096 centidegree
	function automatic logic [ATAN_W-1:0] atan_lut(input logic [4:0] i);
		logic [ATAN_W-1:0] r;
		case (i)
			5'd0:  r = 25'd18432000;
			5'd1:  r = 25'd10881045;
			5'd2:  r = 25'd5749245;
			5'd3:  r = 25'd2918407;
			5'd4:  r = 25'd1464867;
			5'd5:  r = 25'd733147;
			5'd6:  r = 25'd366663;
			5'd7:  r = 25'd183343;
			5'd8:  r = 25'd91673;
			5'd9:  r = 25'd45837;
			5'd10: r = 25'd22918;
			5'd11: r = 25'd11459;
			5'd12: r = 25'd5730;
			5'd13: r = 25'd2865;
			5'd14: r = 25'd1432;
			5'd15: r = 25'd716;
			5'd16: r = 25'd358;
			5'd17: r = 25'd179;
			5'd18: r = 25'd90;
			5'd19: r = 25'd45;
			5'd20: r = 25'd22;
			5'd21: r = 25'd11;
			5'd22: r = 25'd6;
			5'd23: r = 25'd3;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

// ----- rtl/accel_pitch_angle_top.sv -----
`default_nettype none
// Accelerometer pitch angle. Each transfer on the input channel carries one
// three-axis sample and the index of its sensor; the block subtracts that
// sensor's offsets (index 3, or one at or above SENSOR_COUNT, uses none) and
// returns pitch = atan2(-x, sqrt(y*y + z*z)) in hundredths of a degree,
// rounded to nearest, clamped to +/-9000, with 0 for a zero vector. The
// sensor index is echoed with the result. Fully pipelined: one transfer per
// cycle in and out while out_ready is high; the stages are one offset stage,
// one multiplier stage, one sum stage, 26 square-root stages (one root bit
// each), one CORDIC stage per iteration and one rounding stage.
// Valid bits travel with the data and empty slots collapse under a stall.
// Offsets: 64-bit APB registers at 0x00, 0x08, 0x10 (x in 15:0, y in 31:16,
// z in 47:32, two's complement); writes take effect on the next transfer and
// should be done while the pipeline is empty.
module accel_pitch_angle_top #(
	parameter int SENSOR_COUNT = 3,
	parameter int ANGLE_STAGES = 16
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  psel,
	input  wire logic                                  penable,
	input  wire logic                                  pwrite,
	input  wire logic [apa_pkg::ADDR_W-1:0]            paddr,
	input  wire logic [apa_pkg::DATA_W-1:0]            pwdata,
	output logic      [apa_pkg::DATA_W-1:0]            prdata,
	output logic                                       pready,
	input  wire logic                                  in_valid,
	output logic                                       in_ready,
	input  wire logic [apa_pkg::IDX_W-1:0]             sensor_index,
	input  wire logic signed [apa_pkg::RAW_W-1:0]      accel_x,
	input  wire logic signed [apa_pkg::RAW_W-1:0]      accel_y,
	input  wire logic signed [apa_pkg::RAW_W-1:0]      accel_z,
	output logic                                       out_valid,
	input  wire logic                                  out_ready,
	output logic signed [apa_pkg::PITCH_W-1:0]         pitch_centideg,
	output logic      [apa_pkg::IDX_W-1:0]             sensor_echo
);
	import apa_pkg::*;

	localparam int SQ_STAGES = ROOT_W;
	localparam int SQ_BASE   = 3;
	localparam int CR_BASE   = SQ_BASE + SQ_STAGES;
	localparam int OUT_STAGE = CR_BASE + ANGLE_STAGES;
	localparam int NST       = OUT_STAGE + 1;

	localparam logic signed [15:0] PITCH_MAX = 16'sd9000;
	localparam logic signed [15:0] PITCH_MIN = -16'sd9000;

	// ---------------- configuration registers ----------------
	logic [OFF_W-1:0] off0_q, off1_q, off2_q;
	logic             wr_en;
	logic [IDX_W-1:0] reg_sel;

	assign pready  = 1'b1;
	assign reg_sel = paddr[ADDR_W-1:3];
	assign wr_en   = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off0_q <= '0;
			off1_q <= '0;
			off2_q <= '0;
		end else if (wr_en) begin
			case (reg_sel)
				REG_OFF0: off0_q <= pwdata[OFF_W-1:0];
				REG_OFF1: off1_q <= pwdata[OFF_W-1:0];
				REG_OFF2: off2_q <= pwdata[OFF_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			REG_OFF0: prdata = {{(DATA_W-OFF_W){1'b0}}, off0_q};
			REG_OFF1: prdata = {{(DATA_W-OFF_W){1'b0}}, off1_q};
			REG_OFF2: prdata = {{(DATA_W-OFF_W){1'b0}}, off2_q};
			default:  prdata = '0;
		endcase
	end

	// ---------------- pipeline flow control ----------------
	// a stage loads when it is empty or its content moves on
	logic [NST-1:0] v_q;
	logic [NST:0]   adv;

	always_comb begin
		adv[NST] = out_ready;
		for (int j = NST - 1; j >= 0; j--) begin
			adv[j] = ~v_q[j] | adv[j+1];
		end
	end

	assign in_ready  = adv[0];
	assign out_valid = v_q[NST-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			if (adv[0]) begin
				v_q[0] <= in_valid;
			end
			for (int j = 1; j < NST; j++) begin
				if (adv[j]) begin
					v_q[j] <= v_q[j-1];
				end
			end
		end
	end

	// ---------------- stage 1: offset correction ----------------
	logic [OFF_W-1:0]         off_sel;
	side_t                    side_s1;
	logic signed [CORR_W-1:0] cy_s1, cz_s1;
	logic signed [CORR_W-1:0] cx_d, cy_d, cz_d;

	always_comb begin
		off_sel = '0;
		if (int'(sensor_index) < SENSOR_COUNT && int'(sensor_index) < REG_COUNT) begin
			case (sensor_index)
				REG_OFF0: off_sel = off0_q;
				REG_OFF1: off_sel = off1_q;
				REG_OFF2: off_sel = off2_q;
				default:  off_sel = '0;
			endcase
		end
		cx_d = CORR_W'(accel_x) - CORR_W'($signed(off_sel[15:0]));
		cy_d = CORR_W'(accel_y) - CORR_W'($signed(off_sel[31:16]));
		cz_d = CORR_W'(accel_z) - CORR_W'($signed(off_sel[47:32]));
	end

	always_ff @(posedge clk) begin
		if (adv[0]) begin
			side_s1.idx  <= sensor_index;
			side_s1.cx   <= cx_d;
			side_s1.zero <= (cx_d == '0) && (cy_d == '0) && (cz_d == '0);
			cy_s1        <= cy_d;
			cz_s1        <= cz_d;
		end
	end

	// ---------------- stage 2: squares ----------------
	side_t             side_s2;
	logic [SQR_W-1:0]  sqy_s2, sqz_s2;

	// operands widened first so the product keeps all its bits
	always_ff @(posedge clk) begin
		if (adv[1]) begin
			side_s2 <= side_s1;
			sqy_s2  <= $unsigned(SQR_W'(cy_s1) * SQR_W'(cy_s1));
			sqz_s2  <= $unsigned(SQR_W'(cz_s1) * SQR_W'(cz_s1));
		end
	end

	// ---------------- stage 3: radicand (8 fraction bits in the root) ----------------
	side_t            side_s3;
	logic [RAD_W-1:0] rad_s3;

	always_ff @(posedge clk) begin
		if (adv[2]) begin
			side_s3 <= side_s2;
			rad_s3  <= {({1'b0, sqy_s2} + {1'b0, sqz_s2}), 16'd0};
		end
	end

	// ---------------- square root, one bit per stage ----------------
	logic [RAD_W-1:0]  rem_s  [SQ_STAGES];
	logic [ROOT_W-1:0] root_s [SQ_STAGES];
	side_t             sqside_s [SQ_STAGES];

	for (genvar k = 0; k < SQ_STAGES; k++) begin : g_sqrt
		localparam int B = SQ_STAGES - 1 - k;
		logic [RAD_W-1:0]  rem_i;
		logic [ROOT_W-1:0] root_i;
		side_t             side_i;
		logic [RAD_W+1:0]  trial;

		if (k == 0) begin : g_first
			assign rem_i  = rad_s3;
			assign root_i = '0;
			assign side_i = side_s3;
		end else begin : g_next
			assign rem_i  = rem_s[k-1];
			assign root_i = root_s[k-1];
			assign side_i = sqside_s[k-1];
		end

		// (root + 2^B)^2 - root^2
		assign trial = ((RAD_W+2)'(root_i) << (B + 1)) + ((RAD_W+2)'(1) << (2 * B));

		always_ff @(posedge clk) begin
			if (adv[SQ_BASE+k]) begin
				sqside_s[k] <= side_i;
				if ({2'b00, rem_i} >= trial) begin
					rem_s[k]  <= rem_i - trial[RAD_W-1:0];
					root_s[k] <= root_i | (ROOT_W'(1) << B);
				end else begin
					rem_s[k]  <= rem_i;
					root_s[k] <= root_i;
				end
			end
		end
	end

	// ---------------- CORDIC vectoring, one iteration per stage ----------------
	logic signed [CRD_W-1:0] xc_s [ANGLE_STAGES];
	logic signed [CRD_W-1:0] yc_s [ANGLE_STAGES];
	logic signed [CRD_W-1:0] zc_s [ANGLE_STAGES];
	logic [IDX_W-1:0]        idxc_s  [ANGLE_STAGES];
	logic                    zeroc_s [ANGLE_STAGES];

	for (genvar c = 0; c < ANGLE_STAGES; c++) begin : g_cordic
		logic signed [CRD_W-1:0] x_i, y_i, z_i, ang;
		logic [IDX_W-1:0]        idx_i;
		logic                    zero_i;

		if (c == 0) begin : g_first
			assign x_i    = CRD_W'(root_s[SQ_STAGES-1]);
			assign y_i    = -(CRD_W'(sqside_s[SQ_STAGES-1].cx) <<< 8);
			assign z_i    = '0;
			assign idx_i  = sqside_s[SQ_STAGES-1].idx;
			assign zero_i = sqside_s[SQ_STAGES-1].zero;
		end else begin : g_next
			assign x_i    = xc_s[c-1];
			assign y_i    = yc_s[c-1];
			assign z_i    = zc_s[c-1];
			assign idx_i  = idxc_s[c-1];
			assign zero_i = zeroc_s[c-1];
		end

		assign ang = CRD_W'(atan_lut(5'(c)));

		always_ff @(posedge clk) begin
			if (adv[CR_BASE+c]) begin
				idxc_s[c]  <= idx_i;
				zeroc_s[c] <= zero_i;
				if (!y_i[CRD_W-1]) begin
					xc_s[c] <= x_i + (y_i >>> c);
					yc_s[c] <= y_i - (x_i >>> c);
					zc_s[c] <= z_i + ang;
				end else begin
					xc_s[c] <= x_i - (y_i >>> c);
					yc_s[c] <= y_i + (x_i >>> c);
					zc_s[c] <= z_i - ang;
				end
			end
		end
	end

	// ---------------- rounding and clamp ----------------
	logic signed [CRD_W-1:0] z_rnd;
	logic signed [15:0]      p_full;
	logic signed [PITCH_W-1:0] p_clamp;
	logic signed [PITCH_W-1:0] pitch_s;
	logic [IDX_W-1:0]          echo_s;

	always_comb begin
		z_rnd  = zc_s[ANGLE_STAGES-1] + CRD_W'(2048);
		p_full = 16'(z_rnd >>> 12);
		if (zeroc_s[ANGLE_STAGES-1]) begin
			p_clamp = '0;
		end else if (p_full > PITCH_MAX) begin
			p_clamp = PITCH_W'(PITCH_MAX);
		end else if (p_full < PITCH_MIN) begin
			p_clamp = PITCH_W'(PITCH_MIN);
		end else begin
			p_clamp = PITCH_W'(p_full);
		end
	end

	always_ff @(posedge clk) begin
		if (adv[OUT_STAGE]) begin
			pitch_s <= p_clamp;
			echo_s  <= idxc_s[ANGLE_STAGES-1];
		end
	end

	assign pitch_centideg = pitch_s;
	assign sensor_echo    = echo_s;

endmodule
`default_nettype wire
